@@ rtl/lpht_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package lpht_pkg;
   localparam int TableDepth = 1024;
   localparam int AddrBits = $clog2(TableDepth);
   localparam int CountBits = 11;
   localparam int KeyBits = 64;
   localparam int ValueBits = 32;
   localparam logic [CountBits-1:0] DefaultSize = 11'd10;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   localparam logic [1:0] MarkEmpty = 2'd0;
   localparam logic [1:0] MarkLive = 2'd1;
   localparam logic [1:0] MarkTomb = 2'd2;

   // Write request from the control engine to the slot memory.
   typedef struct packed {
      logic mark_we;
      logic data_we;
      logic key_we;
      logic [AddrBits-1:0] addr;
      logic [1:0] mark;
      logic [KeyBits-1:0] key;
      logic [ValueBits-1:0] data;
   } slot_wr_type;
endpackage
`default_nettype wire

@@ rtl/lpht_hash.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Key hash: one byte per cycle, then the remainder by the capacity one bit per cycle.
module lpht_hash
   import lpht_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic [KeyBits-1:0] raw_key,
   input wire logic [CountBits-1:0] cap,
   output logic done,
   output logic [KeyBits-1:0] norm_key,
   output logic [AddrBits-1:0] home
);
   typedef enum logic [2:0] {
      H_IDLE = 3'b001,
      H_BYTE = 3'b010,
      H_MOD = 3'b100
   } hstate_type;

   hstate_type state_ff, state_in;
   logic [KeyBits-1:0] shift_ff, shift_in, key_ff, key_in, h_ff, h_in;
   logic [3:0] byte_ff, byte_in;
   logic [6:0] bit_ff, bit_in;
   logic [CountBits:0] rem_ff, rem_in;
   logic [CountBits:0] rem_sh;
   logic [7:0] cur;

   assign cur = shift_ff[KeyBits-1 -: 8];
   assign rem_sh = {rem_ff[CountBits-1:0], h_ff[KeyBits-1]};

   always_comb begin
      state_in = state_ff;
      shift_in = shift_ff;
      key_in = key_ff;
      h_in = h_ff;
      byte_in = byte_ff;
      bit_in = bit_ff;
      rem_in = rem_ff;
      done = 1'b0;
      unique case (state_ff)
         H_IDLE: begin
            if (start) begin
               shift_in = raw_key;
               key_in = '0;
               h_in = '0;
               byte_in = '0;
               state_in = H_BYTE;
            end
         end
         H_BYTE: begin
            // Stop at the first zero byte or after eight bytes.
            if (cur == 8'd0 || byte_ff == 4'd8) begin
               rem_in = '0;
               bit_in = '0;
               state_in = H_MOD;
            end else begin
               h_in = (h_ff << 5) - h_ff + {56'd0, cur};
               key_in = key_ff | ({56'd0, cur} << (7'd56 - {byte_ff[2:0], 3'b000}));
               shift_in = shift_ff << 8;
               byte_in = byte_ff + 4'd1;
            end
         end
         H_MOD: begin
            // Restoring remainder, one hash bit per cycle.
            if (bit_ff == 7'd64) begin
               done = 1'b1;
               state_in = H_IDLE;
            end else begin
               if (rem_sh >= {1'b0, cap}) rem_in = rem_sh - {1'b0, cap};
               else rem_in = rem_sh;
               h_in = h_ff << 1;
               bit_in = bit_ff + 7'd1;
            end
         end
         default: state_in = H_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= H_IDLE;
      else state_ff <= state_in;
      shift_ff <= shift_in;
      key_ff <= key_in;
      h_ff <= h_in;
      byte_ff <= byte_in;
      bit_ff <= bit_in;
      rem_ff <= rem_in;
   end

   assign norm_key = key_ff;
   assign home = rem_ff[AddrBits-1:0];

   a_home_in_range: assert property (@(posedge clock) disable iff (reset)
      done |-> ({1'b0, rem_ff} < {1'b0, cap})) else $error("home slot out of range");
endmodule
`default_nettype wire

@@ rtl/lpht_slots.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Slot memories: marks with a clearing pass, keys and data, registered reads.
module lpht_slots
   import lpht_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic clear_req,
   output logic clearing,
   input wire logic [AddrBits-1:0] rd_addr,
   output logic [1:0] rd_mark,
   output logic [KeyBits-1:0] rd_key,
   output logic [ValueBits-1:0] rd_data,
   input wire slot_wr_type wr
);
   logic [1:0] mark_mem [TableDepth];
   logic [KeyBits-1:0] key_mem [TableDepth];
   logic [ValueBits-1:0] data_mem [TableDepth];
   logic clr_ff, clr_in;
   logic [AddrBits-1:0] clr_addr_ff, clr_addr_in;

   // Clearing sweep over the mark memory, one entry per cycle.
   always_comb begin
      clr_in = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clear_req) begin
         clr_in = 1'b1;
         clr_addr_in = '0;
      end else if (clr_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == AddrBits'(TableDepth - 1)) clr_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   assign clearing = clr_ff;

   // Mark memory.
   always_ff @(posedge clock) begin
      if (clr_ff) mark_mem[clr_addr_ff] <= MarkEmpty;
      else if (wr.mark_we) mark_mem[wr.addr] <= wr.mark;
      rd_mark <= mark_mem[rd_addr];
   end

   // Key and data memories.
   always_ff @(posedge clock) begin
      if (wr.key_we) key_mem[wr.addr] <= wr.key;
      if (wr.data_we) data_mem[wr.addr] <= wr.data;
      rd_key <= key_mem[rd_addr];
      rd_data <= data_mem[rd_addr];
   end

   a_no_write_clear: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !wr.mark_we) else $error("write during clear");
endmodule
`default_nettype wire

@@ rtl/lpht_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Probe sequencer: walks the chain, then updates the slot and reports.
module lpht_ctrl
   import lpht_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic go,
   input wire cmd_type cmd,
   input wire logic [ValueBits-1:0] value,
   input wire logic hash_done,
   input wire logic [KeyBits-1:0] norm_key,
   input wire logic [AddrBits-1:0] home,
   input wire logic [CountBits-1:0] cap,
   input wire logic clear_req,
   output logic [AddrBits-1:0] rd_addr,
   input wire logic [1:0] rd_mark,
   input wire logic [KeyBits-1:0] rd_key,
   input wire logic [ValueBits-1:0] rd_data,
   output slot_wr_type wr,
   output logic done,
   output status_type status,
   output logic [ValueBits-1:0] read_value,
   output logic [CountBits-1:0] entry_count
);
   typedef enum logic [3:0] {
      C_IDLE = 4'b0001,
      C_HASH = 4'b0010,
      C_PROBE = 4'b0100,
      C_FINISH = 4'b1000
   } cstate_type;

   cstate_type state_ff, state_in;
   cmd_type cmd_ff, cmd_in;
   logic [ValueBits-1:0] val_ff, val_in;
   logic [AddrBits-1:0] pos_ff, pos_in, free_ff, free_in, found_ff, found_in;
   logic [CountBits-1:0] n_ff, n_in, count_ff, count_in;
   logic hit_ff, hit_in, hfree_ff, hfree_in, wait_ff, wait_in;
   logic [AddrBits-1:0] next_pos;

   assign next_pos = ({1'b0, pos_ff} + 1'b1 >= (AddrBits+1)'(cap)) ? '0 : pos_ff + 1'b1;
   assign rd_addr = pos_in;

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      val_in = val_ff;
      pos_in = pos_ff;
      free_in = free_ff;
      found_in = found_ff;
      n_in = n_ff;
      count_in = count_ff;
      hit_in = hit_ff;
      hfree_in = hfree_ff;
      wait_in = 1'b0;
      wr = '0;
      wr.addr = found_ff;
      wr.key = norm_key;
      wr.data = val_ff;
      wr.mark = MarkLive;
      done = 1'b0;
      status = ST_OK;
      read_value = '0;
      unique case (state_ff)
         C_IDLE: begin
            if (go) begin
               cmd_in = cmd;
               val_in = value;
               state_in = C_HASH;
            end
         end
         C_HASH: begin
            if (hash_done) begin
               pos_in = home;
               n_in = '0;
               hit_in = 1'b0;
               hfree_in = 1'b0;
               wait_in = 1'b1;
               state_in = (cmd_ff == CMD_NONE) ? C_FINISH : C_PROBE;
            end
         end
         C_PROBE: begin
            // Data of slot pos_ff arrives this cycle.
            if (wait_ff) begin
               wait_in = 1'b0;
            end else if (rd_mark == MarkLive) begin
               if (rd_key == norm_key) begin
                  hit_in = 1'b1;
                  found_in = pos_ff;
                  state_in = C_FINISH;
               end else if (n_ff + 1'b1 >= cap) begin
                  state_in = C_FINISH;
               end else begin
                  pos_in = next_pos;
                  n_in = n_ff + 1'b1;
                  wait_in = 1'b1;
               end
            end else if (rd_mark == MarkTomb) begin
               if (!hfree_ff) begin
                  hfree_in = 1'b1;
                  free_in = pos_ff;
               end
               if (n_ff + 1'b1 >= cap) begin
                  state_in = C_FINISH;
               end else begin
                  pos_in = next_pos;
                  n_in = n_ff + 1'b1;
                  wait_in = 1'b1;
               end
            end else begin
               if (!hfree_ff) begin
                  hfree_in = 1'b1;
                  free_in = pos_ff;
               end
               state_in = C_FINISH;
            end
         end
         C_FINISH: begin
            done = 1'b1;
            state_in = C_IDLE;
            case (cmd_ff)
               CMD_INSERT: begin
                  if (hit_ff) begin
                     wr.data_we = 1'b1;
                  end else if (hfree_ff) begin
                     wr.addr = free_ff;
                     wr.mark_we = 1'b1;
                     wr.key_we = 1'b1;
                     wr.data_we = 1'b1;
                     count_in = count_ff + 1'b1;
                  end else begin
                     status = ST_FULL;
                  end
               end
               CMD_LOOKUP: begin
                  if (hit_ff) read_value = rd_data;
                  else status = ST_NOT_FOUND;
               end
               CMD_DELETE: begin
                  if (hit_ff) begin
                     wr.mark_we = 1'b1;
                     wr.mark = MarkTomb;
                     if (count_ff != '0) count_in = count_ff - 1'b1;
                  end else begin
                     status = ST_NOT_FOUND;
                  end
               end
               default: ;
            endcase
         end
         default: state_in = C_IDLE;
      endcase
      if (clear_req) count_in = '0;
   end

   // rd_data still holds the hit slot in the finish cycle since pos is unchanged.
   assign entry_count = count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         count_ff <= '0;
         wait_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         wait_ff <= wait_in;
      end
      cmd_ff <= cmd_in;
      val_ff <= val_in;
      pos_ff <= pos_in;
      free_ff <= free_in;
      found_ff <= found_in;
      n_ff <= n_in;
      hit_ff <= hit_in;
      hfree_ff <= hfree_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountBits'(TableDepth)) else $error("count overflow");
   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == C_PROBE |-> n_ff < cap) else $error("probe ran past capacity");
   a_done_one: assert property (@(posedge clock) disable iff (reset)
      done |=> !done) else $error("double result");
endmodule
`default_nettype wire

@@ rtl/linear_probe_hash_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Key-value table with open addressing and linear probing.
// Request channel: drive req_cmd, req_key, req_value and pulse start while busy
// is low; the word is taken at that clock edge and busy stays high until the
// result is out.
// Result channel: rsp_strobe is high for one cycle with rsp_status,
// rsp_read_value and rsp_entry_count; the receiver cannot stall it.
// Per word: the hash takes the key one byte at a time, then the bit-serial
// remainder of the 64-bit hash follows; each probed slot is then read and
// checked, and a finish step updates the slot and reports; command 3 skips the
// probe. busy is still high in the strobe cycle, so the next word is taken
// in the cycle after the strobe at the earliest.
// Configuration: csr_valid/csr_ready write table_size (zero means 10, values
// above 1024 saturate); the write clears the table with a sweep over all 1024
// entries of the mark memory during which busy is high. busy is also high while
// csr_valid is, so a word is never taken together with a write. Reset starts
// the same sweep, with table_size 10 and the entry count at zero.
module linear_probe_hash_table
   import lpht_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire logic [1:0] req_cmd,
   input wire logic [63:0] req_key,
   input wire logic [31:0] req_value,
   output logic rsp_strobe,
   output logic [1:0] rsp_status,
   output logic [31:0] rsp_read_value,
   output logic [10:0] rsp_entry_count,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [10:0] csr_table_size
);
   logic [CountBits-1:0] size_ff, cap;
   logic active_ff, go, clear_req, clearing, hash_done, done;
   logic [KeyBits-1:0] norm_key, rd_key;
   logic [AddrBits-1:0] home, rd_addr;
   logic [1:0] rd_mark;
   logic [ValueBits-1:0] rd_data, read_value;
   logic [CountBits-1:0] entry_count;
   status_type status;
   slot_wr_type wr;
   logic strobe_ff;
   logic [1:0] status_ff;
   logic [31:0] rv_ff;
   logic [10:0] count_ff;

   assign busy = active_ff || clearing || strobe_ff || csr_valid;
   assign csr_ready = !active_ff;
   assign go = start && !busy;
   assign clear_req = csr_valid && csr_ready;

   // Effective capacity.
   always_comb begin
      if (size_ff == '0) cap = DefaultSize;
      else if (size_ff > CountBits'(TableDepth)) cap = CountBits'(TableDepth);
      else cap = size_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= DefaultSize;
         active_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         if (clear_req) size_ff <= csr_table_size;
         if (go) active_ff <= 1'b1;
         else if (done) active_ff <= 1'b0;
         strobe_ff <= done;
      end
      status_ff <= status;
      rv_ff <= read_value;
      count_ff <= entry_count;
   end

   lpht_hash u_hash (
      .clock, .reset, .start(go), .raw_key(req_key), .cap,
      .done(hash_done), .norm_key, .home
   );

   lpht_slots u_slots (
      .clock, .reset, .clear_req, .clearing, .rd_addr, .rd_mark, .rd_key, .rd_data, .wr
   );

   lpht_ctrl u_ctrl (
      .clock, .reset, .go, .cmd(cmd_type'(req_cmd)), .value(req_value), .hash_done,
      .norm_key, .home, .cap, .clear_req, .rd_addr, .rd_mark, .rd_key, .rd_data, .wr,
      .done, .status, .read_value, .entry_count
   );

   assign rsp_strobe = strobe_ff;
   assign rsp_status = status_ff;
   assign rsp_read_value = rv_ff;
   assign rsp_entry_count = count_ff;
endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
   import lpht_pkg::*;

   localparam int CycleLimit = 6000000;
   localparam int DirRows = 24;

   // One expected response word.
   typedef struct packed {
      logic [1:0] status;
      logic [31:0] read_value;
      logic [10:0] entry_count;
   } rsp_word_type;

   // One row of the directed table; has_exp marks a hand-written expectation.
   typedef struct packed {
      logic [1:0] cmd;
      logic [63:0] key;
      logic [31:0] value;
      logic has_exp;
      rsp_word_type exp_rsp;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   logic [1:0] req_cmd;
   logic [63:0] req_key;
   logic [31:0] req_value;
   logic rsp_strobe;
   logic [1:0] rsp_status;
   logic [31:0] rsp_read_value;
   logic [10:0] rsp_entry_count;
   logic csr_valid;
   logic csr_ready;
   logic [10:0] csr_table_size;

   // Shadow copy of the table.
   logic [1:0] shadow_mark [TableDepth];
   logic [63:0] shadow_key [TableDepth];
   logic [31:0] shadow_data [TableDepth];
   int unsigned shadow_count;
   logic [10:0] shadow_size;

   rsp_word_type pending_rsp [$];
   int unsigned mismatches;
   int unsigned cycles;
   int unsigned send_idle_pct;
   logic [63:0] key_pool [$];

   dir_row_type dir_rows [0:DirRows-1] = '{
      '{CMD_LOOKUP, 64'h4100_0000_0000_0000, 32'h0, 1'b1, '{ST_NOT_FOUND, 32'h0, 11'd0}},
      '{CMD_DELETE, 64'h4100_0000_0000_0000, 32'h0, 1'b1, '{ST_NOT_FOUND, 32'h0, 11'd0}},
      '{CMD_INSERT, 64'h0, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 32'h0, 11'd1}},
      '{CMD_LOOKUP, 64'h00FF_FFFF_FFFF_FFFF, 32'h0, 1'b1, '{ST_OK, 32'hFFFF_FFFF, 11'd1}},
      '{CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1'b1, '{ST_OK, 32'h0, 11'd2}},
      '{CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'h1234, 1'b1, '{ST_OK, 32'h0, 11'd2}},
      '{CMD_INSERT, 64'h4100_5A5A_0000_1111, 32'h5, 1'b0, '0},
      '{CMD_INSERT, 64'h4100_A5A5_FFFF_EEEE, 32'h6, 1'b0, '0},
      '{CMD_LOOKUP, 64'h4100_0000_0000_0000, 32'h0, 1'b0, '0},
      '{CMD_NONE, 64'h4100_0000_0000_0000, 32'h77, 1'b0, '0},
      '{CMD_DELETE, 64'h4100_0000_0000_0001, 32'h0, 1'b0, '0},
      '{CMD_LOOKUP, 64'h4100_0000_0000_0000, 32'h0, 1'b0, '0},
      '{CMD_DELETE, 64'h0000_1234_0000_0000, 32'h0, 1'b0, '0},
      '{CMD_INSERT, 64'h0100_0000_0000_0000, 32'h11, 1'b0, '0},
      '{CMD_INSERT, 64'h0200_0000_0000_0000, 32'h12, 1'b0, '0},
      '{CMD_INSERT, 64'h0300_0000_0000_0000, 32'h13, 1'b0, '0},
      '{CMD_INSERT, 64'h0400_0000_0000_0000, 32'h14, 1'b0, '0},
      '{CMD_INSERT, 64'h0500_0000_0000_0000, 32'h15, 1'b0, '0},
      '{CMD_INSERT, 64'h0600_0000_0000_0000, 32'h16, 1'b0, '0},
      '{CMD_INSERT, 64'h0700_0000_0000_0000, 32'h17, 1'b0, '0},
      '{CMD_INSERT, 64'h0800_0000_0000_0000, 32'h18, 1'b0, '0},
      '{CMD_INSERT, 64'h0900_0000_0000_0000, 32'h19, 1'b0, '0},
      '{CMD_INSERT, 64'h0A00_0000_0000_0000, 32'h1A, 1'b0, '0},
      '{CMD_LOOKUP, 64'h0500_0000_0000_0000, 32'h0, 1'b0, '0}
   };

   linear_probe_hash_table i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_cmd(req_cmd),
      .req_key(req_key),
      .req_value(req_value),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_read_value(rsp_read_value),
      .rsp_entry_count(rsp_entry_count),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_table_size(csr_table_size)
   );

   // Clock with a 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Empty every slot and zero the count.
   function automatic void clear_shadow();
      for (int i = 0; i < TableDepth; i++) begin
         shadow_mark[i] = MarkEmpty;
         shadow_key[i] = '0;
         shadow_data[i] = '0;
      end
      shadow_count = 0;
   endfunction

   // Applies one command word to the shadow table and returns its response.
   function automatic rsp_word_type table_apply(logic [1:0] cmd, logic [63:0] raw_key,
                                                logic [31:0] value);
      rsp_word_type rsp;
      logic [63:0] hash;
      logic [63:0] norm_key;
      logic [7:0] byte_val;
      int unsigned cap;
      int unsigned pos;
      int unsigned hit_pos;
      int unsigned free_pos;
      bit hit;
      bit have_free;
      bit done;
      hash = '0;
      norm_key = '0;
      done = 1'b0;
      hit = 1'b0;
      have_free = 1'b0;
      hit_pos = 0;
      free_pos = 0;
      rsp = '{ST_OK, 32'h0, 11'd0};
      // The key ends at its first zero byte.
      for (int i = 0; i < 8; i++) begin
         byte_val = raw_key[63 - 8 * i -: 8];
         if (byte_val == 8'h0) done = 1'b1;
         if (!done) begin
            norm_key[63 - 8 * i -: 8] = byte_val;
            hash = hash * 64'd31 + {56'h0, byte_val};
         end
      end
      cap = (shadow_size == 11'd0) ? int'(DefaultSize) : int'(shadow_size);
      if (cap > TableDepth) cap = TableDepth;
      pos = int'(hash % 64'(cap));
      if (cmd != CMD_NONE) begin
         done = 1'b0;
         // Probe walk: stop on a hit, at the first empty slot or after cap slots.
         for (int n = 0; n < cap && !done; n++) begin
            if (shadow_mark[pos] == MarkLive) begin
               if (shadow_key[pos] == norm_key) begin
                  hit = 1'b1;
                  hit_pos = pos;
                  done = 1'b1;
               end
            end else begin
               if (!have_free) begin
                  have_free = 1'b1;
                  free_pos = pos;
               end
               if (shadow_mark[pos] != MarkTomb) done = 1'b1;
            end
            if (!done) pos = (pos + 1 >= cap) ? 0 : pos + 1;
         end
         case (cmd)
            CMD_INSERT: begin
               if (hit) begin
                  shadow_data[hit_pos] = value;
               end else if (have_free) begin
                  shadow_mark[free_pos] = MarkLive;
                  shadow_key[free_pos] = norm_key;
                  shadow_data[free_pos] = value;
                  shadow_count++;
               end else begin
                  rsp.status = ST_FULL;
               end
            end
            CMD_LOOKUP: begin
               if (hit) rsp.read_value = shadow_data[hit_pos];
               else rsp.status = ST_NOT_FOUND;
            end
            default: begin
               if (hit) begin
                  shadow_mark[hit_pos] = MarkTomb;
                  if (shadow_count > 0) shadow_count--;
               end else begin
                  rsp.status = ST_NOT_FOUND;
               end
            end
         endcase
      end
      rsp.entry_count = shadow_count[10:0];
      return rsp;
   endfunction

   // Presents one word and holds it until it is taken.
   task automatic send_word(logic [1:0] cmd, logic [63:0] key, logic [31:0] value,
                            bit has_exp, rsp_word_type exp_rsp);
      rsp_word_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= cmd;
      req_key <= key;
      req_value <= value;
      do @(posedge clock); while (busy);
      predicted = table_apply(cmd, key, value);
      pending_rsp.push_back(has_exp ? exp_rsp : predicted);
   endtask

   // Writes table_size once the block has drained, then updates the shadow.
   task automatic write_table_size(logic [10:0] size_val);
      start <= 1'b0;
      wait (pending_rsp.size() == 0);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_table_size <= size_val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      shadow_size = size_val;
      clear_shadow();
   endtask

   // Builds a key of random length; bytes after the terminating zero are left random.
   function automatic logic [63:0] make_key();
      logic [63:0] k;
      int unsigned len;
      k = {$urandom, $urandom};
      len = $urandom_range(0, 8);
      for (int i = 0; i < 8; i++) begin
         if (i < len) begin
            if (k[63 - 8 * i -: 8] == 8'h0) k[63 - 8 * i -: 8] = 8'h1;
         end else if (i == len) begin
            k[63 - 8 * i -: 8] = 8'h0;
         end
      end
      return k;
   endfunction

   // Picks a word: mostly keys from a small pool so that hits and chains occur.
   task automatic send_random();
      logic [63:0] k;
      logic [63:0] junk;
      logic [63:0] tail_mask;
      logic [1:0] cmd;
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 45) cmd = CMD_INSERT;
      else if (sel < 72) cmd = CMD_LOOKUP;
      else if (sel < 96) cmd = CMD_DELETE;
      else cmd = CMD_NONE;
      if ($urandom_range(99) < 4) begin
         k = {$urandom, $urandom};
      end else begin
         k = key_pool[$urandom_range(key_pool.size() - 1)];
         // Junk after the terminating zero byte must not change the key.
         if ($urandom_range(1) == 1) begin
            for (int i = 0; i < 8; i++) begin
               if (k[63 - 8 * i -: 8] == 8'h0) begin
                  junk = {$urandom, $urandom};
                  tail_mask = ~64'h0 >> (8 * (i + 1));
                  k = (k & ~tail_mask) | (junk & tail_mask);
                  break;
               end
            end
         end
      end
      send_word(cmd, k, $urandom, 1'b0, '0);
   endtask

   // Response checker.
   always @(posedge clock) begin
      rsp_word_type exp_rsp;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: status %0d value %h count %0d",
                        rsp_status, rsp_read_value, rsp_entry_count);
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_status !== exp_rsp.status || rsp_read_value !== exp_rsp.read_value
                || rsp_entry_count !== exp_rsp.entry_count) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: status %0d/%0d value %h/%h count %0d/%0d (exp/act)",
                           exp_rsp.status, rsp_status, exp_rsp.read_value,
                           rsp_read_value, exp_rsp.entry_count, rsp_entry_count);
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("[linear_probe_hash_table] ERROR");
         $finish;
      end
   end

   initial begin
      logic [10:0] sizes [10] = '{11'd1, 11'd2, 11'd3, 11'd0, 11'd7, 11'd16,
                                  11'd2047, 11'd5, 11'd1024, 11'd31};
      int unsigned idle_modes [4] = '{0, 47, 0, 8};
      int unsigned pool_len;
      int unsigned cap;
      mismatches = 0;
      cycles = 0;
      send_idle_pct = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_cmd <= CMD_NONE;
      req_key <= '0;
      req_value <= '0;
      csr_valid <= 1'b0;
      csr_table_size <= '0;
      shadow_size = DefaultSize;
      clear_shadow();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset size of ten slots.
      for (int r = 0; r < DirRows; r++)
         send_word(dir_rows[r].cmd, dir_rows[r].key, dir_rows[r].value,
                   dir_rows[r].has_exp, dir_rows[r].exp_rsp);

      // Random part, one table size per phase.
      for (int p = 0; p < 10; p++) begin
         write_table_size(sizes[p]);
         send_idle_pct = idle_modes[p % 4];
         cap = (sizes[p] == 0) ? 10 : (sizes[p] > TableDepth ? TableDepth : sizes[p]);
         pool_len = (cap * 2 + 2 > 40) ? 40 : cap * 2 + 2;
         key_pool.delete();
         for (int i = 0; i < pool_len; i++) key_pool.push_back(make_key());
         for (int n = 0; n < 125; n++) begin
            // Halfway through one phase, let everything drain before going on.
            if (p == 4 && n == 60) begin
               start <= 1'b0;
               wait (pending_rsp.size() == 0);
               @(posedge clock);
            end
            send_random();
         end
      end

      start <= 1'b0;
      wait (pending_rsp.size() == 0);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("[linear_probe_hash_table] OK");
      end else begin
         $display("[linear_probe_hash_table] ERROR");
      end
      $finish;
   end
endmodule
